[hw/rtl/usbcer_pkg.sv]
`timescale 1ns / 1ps
package usbcer_pkg;

    localparam int RomDepth  = 256;
    localparam int RomAw     = 8;
    localparam int MaxPacket = 16;
    localparam int MinPacket = 8;

    // Operation codes of an input item.
    localparam logic [1:0] OP_SETUP   = 2'd0;
    localparam logic [1:0] OP_OUT     = 2'd1;
    localparam logic [1:0] OP_IN_DONE = 2'd2;

    // Result kinds.
    localparam logic [1:0] KIND_DATA   = 2'd0;
    localparam logic [1:0] KIND_EMPTY  = 2'd1;
    localparam logic [1:0] KIND_ADDR   = 2'd2;
    localparam logic [1:0] KIND_ENABLE = 2'd3;

    // Standard request codes and the class request SET_IDLE.
    localparam logic [7:0] REQ_SET_ADDRESS = 8'h05;
    localparam logic [7:0] REQ_GET_DESC    = 8'h06;
    localparam logic [7:0] REQ_SET_CONFIG  = 8'h09;
    localparam logic [7:0] REQ_SET_IDLE    = 8'h0A;

    // Type field of the request type byte.
    localparam logic [1:0] RTYPE_STANDARD = 2'd0;
    localparam logic [1:0] RTYPE_CLASS    = 2'd1;

    // Descriptor types.
    localparam logic [7:0] DT_DEVICE = 8'h01;
    localparam logic [7:0] DT_CONFIG = 8'h02;
    localparam logic [7:0] DT_STRING = 8'h03;
    localparam logic [7:0] DT_REPORT = 8'h22;

    // Commands passed from the decoder to the sequencer.
    typedef enum logic [2:0] {
        CMD_START  = 3'd0,
        CMD_NEXT   = 3'd1,
        CMD_ADDR   = 3'd2,
        CMD_CONFIG = 3'd3,
        CMD_STATUS = 3'd4
    } cmd_code_t;

    typedef struct packed {
        cmd_code_t   code;
        logic [7:0]  offset;
        logic [15:0] length;
        logic [7:0]  value;
    } cmd_t;

    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] data;
        logic       last;
        logic [6:0] addr;
        logic       en;
    } result_t;

    // Descriptor table: device, configuration, report and string descriptors.
    function automatic logic [7:0] rom_byte(input logic [RomAw-1:0] a);
        logic [7:0] b;
        unique case (a)
            8'd0: b = 8'h12; 8'd1: b = 8'h01; 8'd2: b = 8'h10; 8'd3: b = 8'h01;
            8'd4: b = 8'h00; 8'd5: b = 8'h00; 8'd6: b = 8'h00; 8'd7: b = 8'h10;
            8'd8: b = 8'h88; 8'd9: b = 8'h88; 8'd10: b = 8'h01; 8'd11: b = 8'h00;
            8'd12: b = 8'h00; 8'd13: b = 8'h01; 8'd14: b = 8'h01; 8'd15: b = 8'h02;
            8'd16: b = 8'h03; 8'd17: b = 8'h01;
            8'd18: b = 8'h09; 8'd19: b = 8'h02; 8'd20: b = 8'h22; 8'd21: b = 8'h00;
            8'd22: b = 8'h01; 8'd23: b = 8'h01; 8'd24: b = 8'h00; 8'd25: b = 8'h80;
            8'd26: b = 8'h32;
            8'd27: b = 8'h09; 8'd28: b = 8'h04; 8'd29: b = 8'h00; 8'd30: b = 8'h00;
            8'd31: b = 8'h01; 8'd32: b = 8'h03; 8'd33: b = 8'h01; 8'd34: b = 8'h02;
            8'd35: b = 8'h00;
            8'd36: b = 8'h09; 8'd37: b = 8'h21; 8'd38: b = 8'h10; 8'd39: b = 8'h01;
            8'd40: b = 8'h21; 8'd41: b = 8'h01; 8'd42: b = 8'h22; 8'd43: b = 8'h34;
            8'd44: b = 8'h00;
            8'd45: b = 8'h07; 8'd46: b = 8'h05; 8'd47: b = 8'h81; 8'd48: b = 8'h03;
            8'd49: b = 8'h10; 8'd50: b = 8'h00; 8'd51: b = 8'h0A;
            8'd52: b = 8'h05; 8'd53: b = 8'h01; 8'd54: b = 8'h09; 8'd55: b = 8'h02;
            8'd56: b = 8'ha1; 8'd57: b = 8'h01; 8'd58: b = 8'h09; 8'd59: b = 8'h01;
            8'd60: b = 8'ha1; 8'd61: b = 8'h00; 8'd62: b = 8'h05; 8'd63: b = 8'h09;
            8'd64: b = 8'h19; 8'd65: b = 8'h01; 8'd66: b = 8'h29; 8'd67: b = 8'h03;
            8'd68: b = 8'h15; 8'd69: b = 8'h00; 8'd70: b = 8'h25; 8'd71: b = 8'h01;
            8'd72: b = 8'h95; 8'd73: b = 8'h03; 8'd74: b = 8'h75; 8'd75: b = 8'h01;
            8'd76: b = 8'h81; 8'd77: b = 8'h02; 8'd78: b = 8'h95; 8'd79: b = 8'h01;
            8'd80: b = 8'h75; 8'd81: b = 8'h05; 8'd82: b = 8'h81; 8'd83: b = 8'h03;
            8'd84: b = 8'h05; 8'd85: b = 8'h01; 8'd86: b = 8'h09; 8'd87: b = 8'h30;
            8'd88: b = 8'h09; 8'd89: b = 8'h31; 8'd90: b = 8'h09; 8'd91: b = 8'h38;
            8'd92: b = 8'h15; 8'd93: b = 8'h81; 8'd94: b = 8'h25; 8'd95: b = 8'h7f;
            8'd96: b = 8'h75; 8'd97: b = 8'h08; 8'd98: b = 8'h95; 8'd99: b = 8'h03;
            8'd100: b = 8'h81; 8'd101: b = 8'h06; 8'd102: b = 8'hc0; 8'd103: b = 8'hc0;
            8'd104: b = 8'h04; 8'd105: b = 8'h03; 8'd106: b = 8'h09; 8'd107: b = 8'h04;
            8'd108: b = 8'd60; 8'd109: b = 8'h03; 8'd110: b = 8'h61; 8'd111: b = 8'hb6;
            8'd112: b = 8'hce; 8'd113: b = 8'h8f; 8'd114: b = 8'hc3; 8'd115: b = 8'h53;
            8'd116: b = 8'hc0; 8'd117: b = 8'h89; 8'd118: b = 8'h11; 8'd119: b = 8'h62;
            8'd120: b = 8'h84; 8'd121: b = 8'h76;
            8'd122: b = 8'h67; 8'd124: b = 8'h69; 8'd126: b = 8'h74; 8'd128: b = 8'h68;
            8'd130: b = 8'h75; 8'd132: b = 8'h62; 8'd134: b = 8'h3a;
            8'd136: b = 8'h58; 8'd138: b = 8'h61; 8'd140: b = 8'h73; 8'd142: b = 8'h73;
            8'd144: b = 8'h61; 8'd146: b = 8'h73; 8'd148: b = 8'h73;
            8'd150: b = 8'h69; 8'd152: b = 8'h6e; 8'd154: b = 8'h58; 8'd156: b = 8'h73;
            8'd158: b = 8'h61; 8'd160: b = 8'h62; 8'd162: b = 8'h65;
            8'd164: b = 8'h72; 8'd166: b = 8'h58;
            8'd168: b = 8'd24; 8'd169: b = 8'h03; 8'd170: b = 8'h70; 8'd172: b = 8'h68;
            8'd174: b = 8'h69; 8'd176: b = 8'h73; 8'd178: b = 8'h6f; 8'd180: b = 8'h6e;
            8'd182: b = 8'h65; 8'd184: b = 8'h72; 8'd186: b = 8'h84; 8'd187: b = 8'h76;
            8'd188: b = 8'hd1; 8'd189: b = 8'h6e; 8'd190: b = 8'h20; 8'd191: b = 8'h9f;
            8'd192: b = 8'd22; 8'd193: b = 8'h03; 8'd194: b = 8'h32; 8'd196: b = 8'h30;
            8'd198: b = 8'h31; 8'd200: b = 8'h37; 8'd202: b = 8'h2d; 8'd204: b = 8'h31;
            8'd206: b = 8'h31; 8'd208: b = 8'h2d; 8'd210: b = 8'h31; 8'd212: b = 8'h36;
            default: b = 8'h00;
        endcase
        return b;
    endfunction

endpackage

[hw/rtl/usbcer_decode.sv]
`timescale 1ns / 1ps
module usbcer_decode
    import usbcer_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [1:0]  operation,
    input  logic [7:0]  request_type,
    input  logic [7:0]  request_code,
    input  logic [15:0] request_value,
    input  logic [15:0] request_length,
    output logic        cmd_valid,
    input  logic        cmd_ready,
    output cmd_t        cmd
);

    logic       valid_reg;
    cmd_t       cmd_reg;
    logic       hit;
    cmd_t       dec;
    logic [7:0] dtype;
    logic [7:0] didx;
    logic       std_in;
    logic       std_out;

    assign dtype   = request_value[15:8];
    assign didx    = request_value[7:0];
    assign std_in  = request_type[7] && (request_type[6:5] == RTYPE_STANDARD);
    assign std_out = !request_type[7] && (request_type[6:5] == RTYPE_STANDARD);

    // Classify the request into a sequencer command.
    always_comb begin
        hit        = 1'b0;
        dec.code   = CMD_STATUS;
        dec.offset = 8'd0;
        dec.length = request_length;
        dec.value  = didx;
        if (operation == OP_IN_DONE) begin
            hit      = 1'b1;
            dec.code = CMD_NEXT;
        end else if (operation == OP_SETUP) begin
            if (std_in && request_code == REQ_GET_DESC) begin
                dec.code = CMD_START;
                priority if (dtype == DT_DEVICE) begin
                    hit = 1'b1; dec.offset = 8'd0; dec.value = 8'd18;
                end else if (dtype == DT_CONFIG) begin
                    hit = 1'b1; dec.offset = 8'd18; dec.value = 8'd34;
                end else if (dtype == DT_REPORT) begin
                    hit = 1'b1; dec.offset = 8'd52; dec.value = 8'd52;
                end else if (dtype == DT_STRING && didx == 8'd0) begin
                    hit = 1'b1; dec.offset = 8'd104; dec.value = 8'd4;
                end else if (dtype == DT_STRING && didx == 8'd1) begin
                    hit = 1'b1; dec.offset = 8'd108; dec.value = 8'd60;
                end else if (dtype == DT_STRING && didx == 8'd2) begin
                    hit = 1'b1; dec.offset = 8'd168; dec.value = 8'd24;
                end else if (dtype == DT_STRING && didx == 8'd3) begin
                    hit = 1'b1; dec.offset = 8'd192; dec.value = 8'd22;
                end else begin
                    hit = 1'b0;
                end
            end else if (std_out && request_code == REQ_SET_ADDRESS) begin
                hit = 1'b1; dec.code = CMD_ADDR;
            end else if (std_out && request_code == REQ_SET_CONFIG) begin
                hit = 1'b1; dec.code = CMD_CONFIG;
            end else if (!request_type[7] && request_type[6:5] == RTYPE_CLASS
                         && request_code == REQ_SET_IDLE) begin
                hit = 1'b1; dec.code = CMD_STATUS;
            end
        end
    end

    assign in_ready  = !valid_reg || cmd_ready;
    assign cmd_valid = valid_reg;
    assign cmd       = cmd_reg;

    // One-entry queue toward the sequencer.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid && hit;
        end
        if (in_ready && in_valid && hit) begin
            cmd_reg <= dec;
        end
    end

endmodule

[hw/rtl/usbcer_sequencer.sv]
`timescale 1ns / 1ps
module usbcer_sequencer
    import usbcer_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic [6:0] packet_size,
    input  logic       cmd_valid,
    output logic       cmd_ready,
    input  cmd_t       cmd,
    output logic       out_valid,
    input  logic       out_ready,
    output result_t    out_data
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_DATA,
        S_EMPTY
    } state_t;

    state_t      state_reg;
    logic [15:0] remain_reg;
    logic [7:0]  pos_reg;
    logic [6:0]  count_reg;
    logic        ovalid_reg;
    result_t     odata_reg;
    logic [6:0]  eff;
    logic [6:0]  nsend;
    logic        ofree;
    logic        emit;
    logic [15:0] len_clamp;
    logic [15:0] rem_adv;

    // Effective packet size, saturated into the legal range.
    always_comb begin
        if (packet_size < 7'(MinPacket)) begin
            eff = 7'(MinPacket);
        end else if (packet_size > 7'(MaxPacket)) begin
            eff = 7'(MaxPacket);
        end else begin
            eff = packet_size;
        end
    end

    function automatic logic [6:0] pkt_len(input logic [15:0] r, input logic [6:0] p);
        return (r >= {9'd0, p}) ? p : r[6:0];
    endfunction

    assign ofree     = !ovalid_reg || out_ready;
    assign cmd_ready = (state_reg == S_IDLE) && ofree;
    assign out_valid = ovalid_reg;
    assign out_data  = odata_reg;
    assign len_clamp = (cmd.length > {8'd0, cmd.value}) ? {8'd0, cmd.value}
                                                         : cmd.length;
    assign rem_adv   = remain_reg - {9'd0, eff};
    assign nsend     = pkt_len(remain_reg, eff);

    // A result is loaded for address and configuration commands, data bytes and empty packets.
    assign emit = ofree && (((state_reg == S_IDLE) && cmd_valid
                             && (cmd.code == CMD_ADDR || cmd.code == CMD_CONFIG))
                            || (state_reg == S_DATA) || (state_reg == S_EMPTY));

    // Command execution and byte streaming.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= S_IDLE;
            remain_reg <= 16'd0;
            pos_reg    <= 8'd0;
            count_reg  <= 7'd0;
            ovalid_reg <= 1'b0;
        end else begin
            if (emit) begin
                ovalid_reg <= 1'b1;
            end else if (out_ready) begin
                ovalid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_IDLE: begin
                    if (cmd_valid && ofree) begin
                        unique case (cmd.code)
                            CMD_START: begin
                                remain_reg <= len_clamp;
                                pos_reg    <= cmd.offset;
                                count_reg  <= 7'd0;
                                state_reg  <= (pkt_len(len_clamp, eff) == 7'd0)
                                              ? S_EMPTY : S_DATA;
                            end
                            CMD_NEXT: begin
                                if (remain_reg >= {9'd0, eff}) begin
                                    remain_reg <= rem_adv;
                                    pos_reg    <= pos_reg + {1'b0, eff};
                                    count_reg  <= 7'd0;
                                    state_reg  <= (pkt_len(rem_adv, eff) == 7'd0)
                                                  ? S_EMPTY : S_DATA;
                                end
                            end
                            CMD_ADDR: begin
                                remain_reg <= 16'd0;
                                odata_reg  <= '{kind: KIND_ADDR, data: 8'd0, last: 1'b0,
                                                addr: cmd.value[6:0], en: 1'b0};
                                state_reg  <= S_EMPTY;
                            end
                            CMD_CONFIG: begin
                                remain_reg <= 16'd0;
                                odata_reg  <= '{kind: KIND_ENABLE, data: 8'd0, last: 1'b0,
                                                addr: 7'd0, en: (cmd.value != 8'd0)};
                                state_reg  <= S_EMPTY;
                            end
                            default: begin
                                remain_reg <= 16'd0;
                                state_reg  <= S_EMPTY;
                            end
                        endcase
                    end
                end
                S_DATA: begin
                    if (ofree) begin
                        odata_reg <= '{kind: KIND_DATA,
                                       data: rom_byte(pos_reg + {1'b0, count_reg}),
                                       last: (count_reg + 7'd1 == nsend),
                                       addr: 7'd0, en: 1'b0};
                        count_reg <= count_reg + 7'd1;
                        if (count_reg + 7'd1 == nsend) begin
                            state_reg <= S_IDLE;
                        end
                    end
                end
                S_EMPTY: begin
                    if (ofree) begin
                        odata_reg <= '{kind: KIND_EMPTY, data: 8'd0, last: 1'b1,
                                       addr: 7'd0, en: 1'b0};
                        state_reg <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

endmodule

[hw/rtl/usb_control_endpoint_responder_unit.sv]
`timescale 1ns / 1ps
// Endpoint-zero responder of a HID mouse device.
// The s_ channel takes one event per request: a decoded setup request, an
// OUT data event or an IN-completed notice, with the event kind on s_tuser.
// The m_ channel gives one result per descriptor byte, empty packet or
// command. A descriptor request streams up to one packet of bytes; an
// IN-completed notice after a full packet streams the next packet or an
// empty one.
// A decoder accepts and classifies events into a one-entry command queue;
// a sequencer executes commands and reads bytes from the descriptor table.
// A command result is registered in the command queue and then in the output
// register; a descriptor byte also waits for the sequencer to enter its data
// state. The sequencer emits its results back to back while the m_ channel is
// free and takes the next command only once it is back in its idle state.
// The cfg channel sets the packet size; it is always ready. It must be
// written only while the block is idle; the block does not enforce this.
// Reset restores packet size 16 and clears the transfer state. When the m_
// channel stalls, the output register holds its result and the sequencer
// and then the decoder stop in turn.
module usb_control_endpoint_responder_unit
    import usbcer_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    // tdata: request_type[7:0], request_code[15:8], request_value[31:16],
    // request_index[47:32], request_length[63:48]
    input  logic [63:0] s_tdata,
    // tuser: operation
    input  logic [1:0]  s_tuser,
    output logic        m_tvalid,
    input  logic        m_tready,
    // tdata: data_byte[7:0], device_address[14:8], endpoints_enabled[15]
    output logic [15:0] m_tdata,
    // tuser: result_kind
    output logic [1:0]  m_tuser,
    output logic        m_tlast,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [6:0]  cfg_data
);

    logic [6:0] psize_reg;
    logic       cmd_valid;
    logic       cmd_ready;
    cmd_t       cmd;
    result_t    res;

    assign cfg_ready = 1'b1;

    // Packet size register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            psize_reg <= 7'd16;
        end else if (cfg_valid) begin
            psize_reg <= cfg_data;
        end
    end

    usbcer_decode u_decode (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .in_valid       (s_tvalid),
        .in_ready       (s_tready),
        .operation      (s_tuser),
        .request_type   (s_tdata[7:0]),
        .request_code   (s_tdata[15:8]),
        .request_value  (s_tdata[31:16]),
        .request_length (s_tdata[63:48]),
        .cmd_valid      (cmd_valid),
        .cmd_ready      (cmd_ready),
        .cmd            (cmd)
    );

    usbcer_sequencer u_sequencer (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .packet_size (psize_reg),
        .cmd_valid   (cmd_valid),
        .cmd_ready   (cmd_ready),
        .cmd         (cmd),
        .out_valid   (m_tvalid),
        .out_ready   (m_tready),
        .out_data    (res)
    );

    assign m_tdata = {res.en, res.addr, res.data};
    assign m_tuser = res.kind;
    assign m_tlast = res.last;

endmodule

[hw/rtl/usbcer_checker.sv]
`timescale 1ns / 1ps
module usbcer_checker
    import usbcer_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [15:0] m_tdata,
    input  logic [1:0]  m_tuser,
    input  logic        m_tlast
);

    // A stalled result holds.
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result changed under stall");

    // Empty packets always close a packet.
    a_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser == KIND_EMPTY |-> m_tlast)
        else $error("empty packet without last");

    // Commands never carry a last marker.
    a_cmd: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tuser == KIND_ADDR || m_tuser == KIND_ENABLE) |-> !m_tlast)
        else $error("command marked last");

    // Nothing is shown right after reset.
    a_reset: assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("result after reset");

endmodule

bind usb_control_endpoint_responder_unit usbcer_checker u_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
);

[bench/tb_usb_control_endpoint_responder_unit.sv]
`timescale 1ns / 1ps
module tb_usb_control_endpoint_responder_unit;
    import usbcer_pkg::*;

    // Request type bytes and codes used only by the stimulus.
    localparam logic [7:0] RT_STD_IN       = 8'h80;
    localparam logic [7:0] RT_STD_OUT      = 8'h00;
    localparam logic [7:0] RT_CLASS_OUT    = 8'h21;
    localparam logic [7:0] DT_UNKNOWN      = 8'h07;
    localparam logic [1:0] OP_RESERVED     = 2'd3;
    localparam int         WATCHDOG_LIMIT  = 4000;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [63:0] s_tdata = '0;
    logic [1:0]  s_tuser = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [15:0] m_tdata;
    logic [1:0]  m_tuser;
    logic        m_tlast;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [6:0]  cfg_data = '0;

    // Predictor copy of the block state.
    logic [6:0]  pkt_size_reg;
    logic [15:0] bytes_left;
    logic [7:0]  rd_ptr;
    logic [7:0]  cfg_value;

    result_t     response_q[$];
    int          error_count = 0;
    int          idle_cycles = 0;
    bit          sink_stalls = 1'b1;
    bit          source_gaps = 1'b1;

    usb_control_endpoint_responder_unit u_top (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .m_tuser(m_tuser), .m_tlast(m_tlast),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
    );

    always #6 aclk = ~aclk;

    // Queue one expected result.
    function automatic void push_result(logic [1:0] kind, logic [7:0] data, logic last,
                                        logic [6:0] addr, logic en);
        result_t r;
        r.kind = kind; r.data = data; r.last = last; r.addr = addr; r.en = en;
        response_q.push_back(r);
    endfunction

    function automatic int eff_packet_size();
        int p;
        p = pkt_size_reg;
        if (p < MinPacket) p = MinPacket;
        if (p > MaxPacket) p = MaxPacket;
        return p;
    endfunction

    // Descriptor table contents, written out independently of the package.
    function automatic logic [7:0] descriptor_byte(int a);
        logic [7:0] img [0:213];
        img = '{
            8'h12,8'h01,8'h10,8'h01,8'h00,8'h00,8'h00,8'h10,8'h88,8'h88,8'h01,8'h00,
            8'h00,8'h01,8'h01,8'h02,8'h03,8'h01,
            8'h09,8'h02,8'h22,8'h00,8'h01,8'h01,8'h00,8'h80,8'h32,
            8'h09,8'h04,8'h00,8'h00,8'h01,8'h03,8'h01,8'h02,8'h00,
            8'h09,8'h21,8'h10,8'h01,8'h21,8'h01,8'h22,8'h34,8'h00,
            8'h07,8'h05,8'h81,8'h03,8'h10,8'h00,8'h0A,
            8'h05,8'h01,8'h09,8'h02,8'ha1,8'h01,8'h09,8'h01,8'ha1,8'h00,8'h05,8'h09,
            8'h19,8'h01,8'h29,8'h03,
            8'h15,8'h00,8'h25,8'h01,8'h95,8'h03,8'h75,8'h01,8'h81,8'h02,8'h95,8'h01,
            8'h75,8'h05,8'h81,8'h03,
            8'h05,8'h01,8'h09,8'h30,8'h09,8'h31,8'h09,8'h38,8'h15,8'h81,8'h25,8'h7f,
            8'h75,8'h08,8'h95,8'h03,
            8'h81,8'h06,8'hc0,8'hc0,
            8'h04,8'h03,8'h09,8'h04,
            8'd60,8'h03,8'h61,8'hb6,8'hce,8'h8f,8'hc3,8'h53,8'hc0,8'h89,8'h11,8'h62,
            8'h84,8'h76,
            8'h67,8'h00,8'h69,8'h00,8'h74,8'h00,8'h68,8'h00,8'h75,8'h00,8'h62,8'h00,
            8'h3a,8'h00,
            8'h58,8'h00,8'h61,8'h00,8'h73,8'h00,8'h73,8'h00,8'h61,8'h00,8'h73,8'h00,
            8'h73,8'h00,
            8'h69,8'h00,8'h6e,8'h00,8'h58,8'h00,8'h73,8'h00,8'h61,8'h00,8'h62,8'h00,
            8'h65,8'h00,
            8'h72,8'h00,8'h58,8'h00,
            8'd24,8'h03,8'h70,8'h00,8'h68,8'h00,8'h69,8'h00,8'h73,8'h00,8'h6f,8'h00,
            8'h6e,8'h00,
            8'h65,8'h00,8'h72,8'h00,8'h84,8'h76,8'hd1,8'h6e,8'h20,8'h9f,
            8'd22,8'h03,8'h32,8'h00,8'h30,8'h00,8'h31,8'h00,8'h37,8'h00,8'h2d,8'h00,
            8'h31,8'h00,
            8'h31,8'h00,8'h2d,8'h00,8'h31,8'h00,8'h36,8'h00};
        return (a < 214) ? img[a] : 8'h00;
    endfunction

    // Expected bytes of one IN packet, or an empty packet when nothing is left.
    function automatic void predict_packet();
        int n;
        int a;
        n = (bytes_left >= eff_packet_size()) ? eff_packet_size() : int'(bytes_left);
        if (n == 0) begin
            push_result(KIND_EMPTY, 8'h00, 1'b1, 7'h00, 1'b0);
        end
        for (int i = 0; i < n; i++) begin
            a = rd_ptr + i;
            push_result(KIND_DATA, (a < RomDepth) ? descriptor_byte(a) : 8'h00,
                        (i + 1 == n), 7'h00, 1'b0);
        end
    endfunction

    function automatic void begin_descriptor(int ofs, int len, logic [15:0] wlen);
        bytes_left = (wlen > len) ? len[15:0] : wlen;
        rd_ptr = ofs[7:0];
        predict_packet();
    endfunction

    // Works out the results of one accepted request.
    function automatic void predict_request(logic [1:0] op, logic [63:0] req);
        logic [7:0]  rtype;
        logic [7:0]  code;
        logic [15:0] wval;
        logic [15:0] wlen;
        rtype = req[7:0]; code = req[15:8];
        wval = req[31:16]; wlen = req[63:48];
        if (op == OP_IN_DONE) begin
            if (bytes_left >= eff_packet_size()) begin
                rd_ptr = rd_ptr + 8'(eff_packet_size());
                bytes_left = bytes_left - 16'(eff_packet_size());
                predict_packet();
            end
        end else if (op == OP_SETUP) begin
            if (rtype[7] && rtype[6:5] == RTYPE_STANDARD && code == REQ_GET_DESC) begin
                case (wval[15:8])
                    DT_DEVICE: begin_descriptor(0, 18, wlen);
                    DT_CONFIG: begin_descriptor(18, 34, wlen);
                    DT_REPORT: begin_descriptor(52, 52, wlen);
                    DT_STRING: begin
                        case (wval[7:0])
                            8'd0: begin_descriptor(104, 4, wlen);
                            8'd1: begin_descriptor(108, 60, wlen);
                            8'd2: begin_descriptor(168, 24, wlen);
                            8'd3: begin_descriptor(192, 22, wlen);
                            default: ;
                        endcase
                    end
                    default: ;
                endcase
            end else if (!rtype[7] && rtype[6:5] == RTYPE_STANDARD
                         && code == REQ_SET_ADDRESS) begin
                push_result(KIND_ADDR, 8'h00, 1'b0, wval[6:0], 1'b0);
                bytes_left = 16'd0;
                predict_packet();
            end else if (!rtype[7] && rtype[6:5] == RTYPE_STANDARD
                         && code == REQ_SET_CONFIG) begin
                cfg_value = wval[7:0];
                push_result(KIND_ENABLE, 8'h00, 1'b0, 7'h00, cfg_value != 8'd0);
                bytes_left = 16'd0;
                predict_packet();
            end else if (!rtype[7] && rtype[6:5] == RTYPE_CLASS && code == REQ_SET_IDLE) begin
                bytes_left = 16'd0;
                predict_packet();
            end
        end
    endfunction

    // Sends one request; random gaps before it while gaps are enabled.
    // Starts and ends at a falling edge with the request left on the bus.
    task automatic send_request(logic [1:0] op, logic [7:0] rtype, logic [7:0] code,
                                logic [15:0] wval, logic [15:0] widx, logic [15:0] wlen);
        if (source_gaps && $urandom_range(0, 3) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(negedge aclk);
        end
        s_tuser <= op;
        s_tdata <= {wlen, widx, wval, code, rtype};
        s_tvalid <= 1'b1;
        do @(posedge aclk); while (!s_tready);
        predict_request(op, {wlen, widx, wval, code, rtype});
        @(negedge aclk);
    endtask

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        while (response_q.size() != 0) @(negedge aclk);
        repeat (20) @(negedge aclk);
    endtask

    task automatic write_packet_size(logic [6:0] v);
        wait_drained();
        cfg_data <= v;
        cfg_valid <= 1'b1;
        do @(posedge aclk); while (!cfg_ready);
        pkt_size_reg = v;
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    task automatic request_descriptor(logic [7:0] dtype, logic [7:0] idx, logic [15:0] wlen);
        send_request(OP_SETUP, RT_STD_IN, REQ_GET_DESC, {dtype, idx}, 16'($urandom), wlen);
    endtask

    // Pulls a whole descriptor through with IN-completed notices.
    task automatic fetch_descriptor(logic [7:0] dtype, logic [7:0] idx, logic [15:0] wlen);
        request_descriptor(dtype, idx, wlen);
        repeat (9) send_request(OP_IN_DONE, 8'($urandom), 8'($urandom), 16'($urandom),
                                16'($urandom), 16'($urandom));
    endtask

    task automatic test_directed();
        request_descriptor(DT_DEVICE, 8'h00, 16'hFFFF);
        send_request(OP_IN_DONE, 8'h00, 8'h00, 16'h0, 16'h0, 16'h0);
        send_request(OP_IN_DONE, 8'hFF, 8'hFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        request_descriptor(DT_CONFIG, 8'h00, 16'd32);
        send_request(OP_IN_DONE, 8'h00, 8'h00, 16'h0, 16'h0, 16'h0);
        send_request(OP_IN_DONE, 8'h00, 8'h00, 16'h0, 16'h0, 16'h0);
        send_request(OP_IN_DONE, 8'h00, 8'h00, 16'h0, 16'h0, 16'h0);
        request_descriptor(DT_REPORT, 8'h00, 16'd0);
        request_descriptor(DT_STRING, 8'h00, 16'd2);
        request_descriptor(DT_STRING, 8'h01, 16'd60);
        request_descriptor(DT_STRING, 8'h02, 16'd24);
        request_descriptor(DT_STRING, 8'h03, 16'd22);
        // Unknown string index and unknown descriptor type give nothing.
        request_descriptor(DT_STRING, 8'h04, 16'd64);
        request_descriptor(DT_UNKNOWN, 8'h00, 16'd64);
        send_request(OP_SETUP, RT_STD_OUT, REQ_SET_ADDRESS, 16'hFFFF, 16'h0, 16'h0);
        send_request(OP_SETUP, RT_STD_OUT, REQ_SET_ADDRESS, 16'h0000, 16'hFFFF, 16'hFFFF);
        send_request(OP_SETUP, RT_STD_OUT, REQ_SET_CONFIG, 16'h0001, 16'h0, 16'h0);
        send_request(OP_SETUP, RT_STD_OUT, REQ_SET_CONFIG, 16'h0000, 16'h0, 16'h0);
        send_request(OP_SETUP, RT_CLASS_OUT, REQ_SET_IDLE, 16'h0000, 16'h0, 16'h0);
        // Wrong direction, OUT data, reserved operation code.
        send_request(OP_SETUP, RT_STD_OUT, REQ_GET_DESC, 16'h0100, 16'h0, 16'd18);
        send_request(OP_OUT, RT_STD_IN, REQ_GET_DESC, 16'h0100, 16'h0, 16'd18);
        send_request(OP_RESERVED, RT_STD_IN, REQ_GET_DESC, 16'h0100, 16'h0, 16'd18);
    endtask

    task automatic test_packet_sizes();
        logic [6:0] sizes [5] = '{7'd8, 7'd64, 7'd0, 7'd127, 7'd11};
        foreach (sizes[i]) begin
            write_packet_size(sizes[i]);
            fetch_descriptor(DT_STRING, 8'h01, 16'hFFFF);
            fetch_descriptor(DT_DEVICE, 8'h00, 16'd16);
        end
        write_packet_size(7'd16);
    endtask

    task automatic send_random_request();
        logic [7:0]  rtype;
        logic [7:0]  code;
        logic [15:0] wval;
        logic [15:0] wlen;
        int          pick;
        pick = $urandom_range(0, 9);
        rtype = 8'($urandom); code = 8'($urandom); wval = 16'($urandom);
        wlen = ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'($urandom_range(0, 70));
        if (pick < 4) begin
            case ($urandom_range(0, 3))
                0: wval[15:8] = DT_DEVICE;
                1: wval[15:8] = DT_CONFIG;
                2: wval[15:8] = DT_REPORT;
                default: wval[15:8] = DT_STRING;
            endcase
            if (wval[15:8] == DT_STRING) wval[7:0] = 8'($urandom_range(0, 4));
            send_request(OP_SETUP, RT_STD_IN, REQ_GET_DESC, wval, 16'($urandom), wlen);
        end else if (pick < 7) begin
            send_request(OP_IN_DONE, rtype, code, wval, 16'($urandom), wlen);
        end else if (pick == 7) begin
            case ($urandom_range(0, 2))
                0: send_request(OP_SETUP, RT_STD_OUT, REQ_SET_ADDRESS, wval,
                                16'($urandom), wlen);
                1: send_request(OP_SETUP, RT_STD_OUT, REQ_SET_CONFIG,
                                {wval[15:8], 8'($urandom_range(0, 2))}, 16'($urandom), wlen);
                default: send_request(OP_SETUP, RT_CLASS_OUT, REQ_SET_IDLE, wval,
                                      16'($urandom), wlen);
            endcase
        end else begin
            send_request(2'($urandom), rtype, code, wval, 16'($urandom), wlen);
        end
    endtask

    task automatic test_random_traffic();
        repeat (100) send_random_request();
        // Hold off until everything is out, then continue.
        wait_drained();
        repeat (60) send_random_request();
    endtask

    task automatic test_no_idling();
        source_gaps = 1'b0;
        sink_stalls = 1'b0;
        repeat (60) send_random_request();
    endtask

    // Result sink with random stall bursts.
    initial begin
        int stall;
        stall = 0;
        forever begin
            @(negedge aclk);
            if (stall > 0) begin
                stall--;
                m_tready <= 1'b0;
            end else if (sink_stalls && $urandom_range(0, 5) == 0) begin
                stall = $urandom_range(0, 7);
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    // Compare each accepted result against the oldest expectation.
    always @(posedge aclk) begin
        result_t exp_r;
        if (aresetn && m_tvalid && m_tready) begin
            if (response_q.size() == 0) begin
                error_count++;
                if (error_count <= 10)
                    $display("Unexpected result: kind %0d tdata %h last %b",
                             m_tuser, m_tdata, m_tlast);
            end else begin
                exp_r = response_q.pop_front();
                if (m_tuser !== exp_r.kind || m_tdata[7:0] !== exp_r.data ||
                    m_tlast !== exp_r.last || m_tdata[14:8] !== exp_r.addr ||
                    m_tdata[15] !== exp_r.en) begin
                    error_count++;
                    if (error_count <= 10) begin
                        $display("Mismatch: expected kind %0d data %h last %b addr %h en %b",
                                 exp_r.kind, exp_r.data, exp_r.last, exp_r.addr, exp_r.en);
                        $display("          actual   kind %0d data %h last %b addr %h en %b",
                                 m_tuser, m_tdata[7:0], m_tlast, m_tdata[14:8], m_tdata[15]);
                    end
                end
            end
        end
    end

    // Watchdog on cycles without any transfer.
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    initial begin
        pkt_size_reg = 7'd16;
        bytes_left = '0;
        rd_ptr = '0;
        cfg_value = '0;
        repeat (8) @(negedge aclk);
        aresetn <= 1'b1;
        test_directed();
        test_packet_sizes();
        test_random_traffic();
        test_no_idling();
        wait_drained();
        if (error_count == 0 && response_q.size() == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
